// ===== sv/eavr_pkg.sv =====
// ----------------------------------------------------------------------------
// eavr_pkg: shared types, constants and functions
// Fixed-point settings, CORDIC angle table and cell data type for the
// Euler angle vector rotator.
// ----------------------------------------------------------------------------
package eavr_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int FRAC_BITS    = 16;
  localparam int SC_W         = FRAC_BITS + 3;
  localparam int Z_W          = 32;
  localparam int VEC_W        = 32;
  localparam int ANG_W        = 16;
  localparam longint GAIN_Q30 = 64'sd652032875;

  typedef logic signed [SC_W-1:0]  sc_t;
  typedef logic signed [Z_W-1:0]   z_t;
  typedef logic signed [VEC_W-1:0] vec_t;

  typedef struct packed {
    sc_t x;
    sc_t y;
    z_t  z;
    logic [1:0] quad;
  } rot_t;

  typedef struct packed {
    rot_t pitch;
    rot_t yaw;
    rot_t roll;
    vec_t vx;
    vec_t vy;
    vec_t vz;
  } cell_t;

  function automatic z_t atan_val(input int i);
    z_t r;
    r = '0;
    unique case (i)
      0: r = 32'sd536870912;
      1: r = 32'sd316933406;
      2: r = 32'sd167458907;
      3: r = 32'sd85004756;
      4: r = 32'sd42667331;
      5: r = 32'sd21354465;
      6: r = 32'sd10679838;
      7: r = 32'sd5340245;
      8: r = 32'sd2670163;
      9: r = 32'sd1335087;
      10: r = 32'sd667544;
      11: r = 32'sd333772;
      12: r = 32'sd166886;
      13: r = 32'sd83443;
      14: r = 32'sd41722;
      15: r = 32'sd20861;
      16: r = 32'sd10430;
      17: r = 32'sd5215;
      18: r = 32'sd2608;
      19: r = 32'sd1304;
      20: r = 32'sd652;
      21: r = 32'sd326;
      22: r = 32'sd163;
      23: r = 32'sd81;
      24: r = 32'sd41;
      25: r = 32'sd20;
      26: r = 32'sd10;
      27: r = 32'sd5;
      28: r = 32'sd3;
      29: r = 32'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic rot_t rot_init(input logic [ANG_W-1:0] ang);
    rot_t r;
    longint g;
    g = (GAIN_Q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    r.x = SC_W'(g);
    r.y = '0;
    r.z = z_t'({ang[13:0], 16'h0000});
    r.quad = ang[15:14];
    return r;
  endfunction

  function automatic rot_t rot_step(input rot_t a, input int i);
    rot_t r;
    sc_t dx;
    sc_t dy;
    dx = a.y >>> i;
    dy = a.x >>> i;
    r = a;
    if (a.z >= 0) begin
      r.x = a.x - dx;
      r.y = a.y + dy;
      r.z = a.z - atan_val(i);
    end else begin
      r.x = a.x + dx;
      r.y = a.y - dy;
      r.z = a.z + atan_val(i);
    end
    return r;
  endfunction

endpackage

// ===== sv/eavr_if.sv =====
// ----------------------------------------------------------------------------
// eavr_in_if / eavr_out_if: valid-ready channels
// Input angles and vector, and the rotated vector result.
// ----------------------------------------------------------------------------
interface eavr_in_if;
  logic valid;
  logic ready;
  logic [eavr_pkg::ANG_W-1:0] pitch;
  logic [eavr_pkg::ANG_W-1:0] yaw;
  logic [eavr_pkg::ANG_W-1:0] roll;
  eavr_pkg::vec_t vec_x;
  eavr_pkg::vec_t vec_y;
  eavr_pkg::vec_t vec_z;
  modport source (output valid, pitch, yaw, roll, vec_x, vec_y, vec_z, input ready);
  modport sink (input valid, pitch, yaw, roll, vec_x, vec_y, vec_z, output ready);
endinterface

interface eavr_out_if;
  logic valid;
  logic ready;
  eavr_pkg::vec_t out_forward;
  eavr_pkg::vec_t out_side;
  eavr_pkg::vec_t out_up;
  modport source (output valid, out_forward, out_side, out_up, input ready);
  modport sink (input valid, out_forward, out_side, out_up, output ready);
endinterface

// ===== sv/euler_angle_vector_rotate.sv =====
// Throughput: one transaction per cycle; the cell chain and matrix stages
// advance together whenever the output register is empty or being read.
// Reset: synchronous active-low rst_n clears all valid flags; data is not reset.
// ----------------------------------------------------------------------------
// euler_angle_vector_rotate: Euler angle rotation of a 3-vector
// A chain of CORDIC cells forms sines and cosines of pitch, yaw and roll,
// then the rotation matrix rows are dotted with the input vector.
// ----------------------------------------------------------------------------
module euler_angle_vector_rotate (
  input  logic       clk,
  input  logic       rst_n,
  eavr_in_if.sink    in_ch,
  eavr_out_if.source out_ch
);
  localparam int N = eavr_pkg::CORDIC_STEPS;

  logic            vld [N+1];
  eavr_pkg::cell_t dat [N+1];
  logic            en;
  logic            m_vld;
  eavr_pkg::vec_t  m_fwd, m_side, m_up;
  logic            ov_r;
  eavr_pkg::vec_t  of_r, os_r, ou_r;

  assign en = !ov_r || out_ch.ready;
  assign in_ch.ready = en;
  assign vld[0] = in_ch.valid;
  assign dat[0].pitch = eavr_pkg::rot_init(in_ch.pitch);
  assign dat[0].yaw   = eavr_pkg::rot_init(in_ch.yaw);
  assign dat[0].roll  = eavr_pkg::rot_init(in_ch.roll);
  assign dat[0].vx = in_ch.vec_x;
  assign dat[0].vy = in_ch.vec_y;
  assign dat[0].vz = in_ch.vec_z;

  for (genvar g = 0; g < N; g++) begin : g_cell
    eavr_cell u_cell (
      .clk, .rst_n, .en,
      .step(5'(g)),
      .vld_in(vld[g]), .d_in(dat[g]),
      .vld_out(vld[g+1]), .d_out(dat[g+1])
    );
  end

  eavr_matrix u_matrix (
    .clk, .rst_n, .en,
    .vld_in(vld[N]), .d_in(dat[N]),
    .vld_out(m_vld), .fwd(m_fwd), .side(m_side), .up(m_up)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= m_vld;
    end
    if (en) begin
      of_r <= m_fwd;
      os_r <= m_side;
      ou_r <= m_up;
    end
  end

  assign out_ch.valid = ov_r;
  assign out_ch.out_forward = of_r;
  assign out_ch.out_side = os_r;
  assign out_ch.out_up = ou_r;
endmodule

// ===== sv/eavr_cell.sv =====
// ----------------------------------------------------------------------------
// eavr_cell: one CORDIC micro-rotation cell
// Rotates the three angle accumulators by one step and passes the data on.
// ----------------------------------------------------------------------------
module eavr_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic [4:0]         step,
  input  logic               vld_in,
  input  eavr_pkg::cell_t    d_in,
  output logic               vld_out,
  output eavr_pkg::cell_t    d_out
);
  logic            vld_r;
  eavr_pkg::cell_t d_r;
  eavr_pkg::cell_t d_nxt;

  always_comb begin
    d_nxt = d_in;
    d_nxt.pitch = eavr_pkg::rot_step(d_in.pitch, int'(step));
    d_nxt.yaw   = eavr_pkg::rot_step(d_in.yaw, int'(step));
    d_nxt.roll  = eavr_pkg::rot_step(d_in.roll, int'(step));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign vld_out = vld_r;
  assign d_out   = d_r;
endmodule

// ===== sv/eavr_matrix.sv =====
// ----------------------------------------------------------------------------
// eavr_matrix: rotation matrix and dot products
// Builds the matrix rows from sines and cosines and forms the saturated
// dot products over four register stages.
// ----------------------------------------------------------------------------
module eavr_matrix (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vld_in,
  input  eavr_pkg::cell_t d_in,
  output logic            vld_out,
  output eavr_pkg::vec_t  fwd,
  output eavr_pkg::vec_t  side,
  output eavr_pkg::vec_t  up
);
  localparam int SW = eavr_pkg::SC_W;
  localparam int PW = 2 * SW;
  localparam int FB = eavr_pkg::FRAC_BITS;
  localparam int MW = SW + 2;
  localparam int DW = eavr_pkg::VEC_W + MW;
  localparam int AW = DW + 2;

  typedef logic signed [SW-1:0] s_t;
  typedef logic signed [MW-1:0] m_t;
  typedef logic signed [DW-1:0] d_t;
  typedef logic signed [AW-1:0] a_t;

  function automatic s_t mulq(input s_t a, input s_t b);
    logic signed [PW-1:0] p;
    p = a * b + (PW'(1) <<< (FB - 1));
    return s_t'(p >>> FB);
  endfunction

  function automatic void quad_map(input eavr_pkg::rot_t r, output s_t c, output s_t s);
    unique case (r.quad)
      2'd0: begin c = r.x;  s = r.y;  end
      2'd1: begin c = -r.y; s = r.x;  end
      2'd2: begin c = -r.x; s = -r.y; end
      default: begin c = r.y; s = -r.x; end
    endcase
  endfunction

  function automatic eavr_pkg::vec_t sat(input a_t v);
    a_t r;
    r = (v + (AW'(1) <<< (FB - 1))) >>> FB;
    if (r > a_t'(32'sh7fffffff)) return 32'sh7fffffff;
    if (r < -a_t'(33'sh80000000)) return 32'sh80000000;
    return eavr_pkg::vec_t'(r);
  endfunction

  logic [3:0] vld_r;
  s_t cp, sp, cy, sy, cr, sr;
  eavr_pkg::vec_t vx1_r, vy1_r, vz1_r, vx2_r, vy2_r, vz2_r;
  s_t srsp_r, crsp_r, cpcy_r, cpsy_r, crsy_r, crcy_r, srcp_r, srsy_r, srcy_r, crcp_r;
  s_t sp2_r, cy2_r, sy2_r;
  m_t m_r [9];
  d_t p_r [9];
  eavr_pkg::vec_t fwd_r, side_r, up_r;

  always_comb begin
    quad_map(d_in.pitch, cp, sp);
    quad_map(d_in.yaw, cy, sy);
    quad_map(d_in.roll, cr, sr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], vld_in};
    end
    if (en) begin
      vx1_r <= d_in.vx;
      vy1_r <= d_in.vy;
      vz1_r <= d_in.vz;

      srsp_r <= mulq(sr, sp);
      crsp_r <= mulq(cr, sp);
      cpcy_r <= mulq(cp, cy);
      cpsy_r <= mulq(cp, sy);
      crsy_r <= mulq(cr, sy);
      crcy_r <= mulq(cr, cy);
      srcp_r <= mulq(sr, cp);
      srsy_r <= mulq(sr, sy);
      srcy_r <= mulq(sr, cy);
      crcp_r <= mulq(cr, cp);
      sp2_r <= sp;
      cy2_r <= cy;
      sy2_r <= sy;
      vx2_r <= vx1_r;
      vy2_r <= vy1_r;
      vz2_r <= vz1_r;

      m_r[0] <= MW'(cpcy_r);
      m_r[1] <= MW'(cpsy_r);
      m_r[2] <= -MW'(sp2_r);
      m_r[3] <= MW'(mulq(srsp_r, cy2_r)) - MW'(crsy_r);
      m_r[4] <= MW'(mulq(srsp_r, sy2_r)) + MW'(crcy_r);
      m_r[5] <= MW'(srcp_r);
      m_r[6] <= MW'(mulq(crsp_r, cy2_r)) + MW'(srsy_r);
      m_r[7] <= MW'(mulq(crsp_r, sy2_r)) - MW'(srcy_r);
      m_r[8] <= MW'(crcp_r);
      for (int k = 0; k < 3; k++) begin
        p_r[3*k]   <= DW'(vx2_r) * DW'(m_r[3*k]);
        p_r[3*k+1] <= DW'(vy2_r) * DW'(m_r[3*k+1]);
        p_r[3*k+2] <= DW'(vz2_r) * DW'(m_r[3*k+2]);
      end
      fwd_r  <= sat(AW'(p_r[0]) + AW'(p_r[1]) + AW'(p_r[2]));
      side_r <= sat(AW'(p_r[3]) + AW'(p_r[4]) + AW'(p_r[5]));
      up_r   <= sat(AW'(p_r[6]) + AW'(p_r[7]) + AW'(p_r[8]));
    end
  end

  assign vld_out = vld_r[3];
  assign fwd  = fwd_r;
  assign side = side_r;
  assign up   = up_r;
endmodule

// ===== sv/eavr_checker.sv =====
// ----------------------------------------------------------------------------
// eavr_checker: port-level checks
// Handshake and flow-control checks on the rotator's ports.
// ----------------------------------------------------------------------------
module eavr_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped while stalled");
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready) else $error("input blocked with empty output");
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready) else $error("input taken during stall");
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("valid after reset");
endmodule

bind euler_angle_vector_rotate eavr_checker u_eavr_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for euler_angle_vector_rotate
// Drives angle and vector transactions through the valid-ready input channel,
// predicts each rotated vector with a CORDIC and matrix model of its own, and
// compares every result transaction field by field under random stalls.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct packed {
    logic [eavr_pkg::ANG_W-1:0] pitch;
    logic [eavr_pkg::ANG_W-1:0] yaw;
    logic [eavr_pkg::ANG_W-1:0] roll;
    logic [31:0]      vx;
    logic [31:0]      vy;
    logic [31:0]      vz;
  } rot_req_t;

  typedef struct packed {
    logic [31:0] fwd;
    logic [31:0] side;
    logic [31:0] up;
  } rot_res_t;

  logic clk;
  logic rst_n;
  eavr_in_if  in_ch ();
  eavr_out_if out_ch ();

  euler_angle_vector_rotate u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  rot_res_t rotated_q[$];
  int       errors;
  int       n_sent;
  int       n_checked;
  int       in_idle_pct;
  int       out_idle_pct;
  int       hold_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("FAILURE");
    $finish;
  end

  function automatic longint floor_shr(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint round_mul(input longint a, input longint b);
    return floor_shr(a * b + (64'sd1 <<< (eavr_pkg::FRAC_BITS - 1)), eavr_pkg::FRAC_BITS);
  endfunction

  function automatic longint turn_angle(input int i);
    longint t[30] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                      21354465, 10679838, 5340245, 2670163, 1335087,
                      667544, 333772, 166886, 83443, 41722,
                      20861, 10430, 5215, 2608, 1304,
                      652, 326, 163, 81, 41, 20, 10, 5, 3, 1};
    return t[i];
  endfunction

  function automatic void angle_sincos(input logic [15:0] ang, output longint c,
                                       output longint s);
    longint x, y, z, dx, dy;
    x = (64'sd652032875 + (64'sd1 <<< (29 - eavr_pkg::FRAC_BITS)))
        >>> (30 - eavr_pkg::FRAC_BITS);
    y = 0;
    z = longint'({ang[13:0], 16'h0000});
    for (int i = 0; i < eavr_pkg::CORDIC_STEPS && i < 30; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= turn_angle(i);
      end else begin
        x += dx; y -= dy; z += turn_angle(i);
      end
    end
    case (ang[15:14])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic logic [31:0] sat_dot(input longint vx, vy, vz, m0, m1, m2);
    longint r;
    r = floor_shr(vx * m0 + vy * m1 + vz * m2 + (64'sd1 <<< (eavr_pkg::FRAC_BITS - 1)),
                  eavr_pkg::FRAC_BITS);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  function automatic rot_res_t rotate_vector(input rot_req_t q);
    longint cp, sp, cy, sy, cr, sr, vx, vy, vz, srsp, crsp;
    rot_res_t r;
    angle_sincos(q.pitch, cp, sp);
    angle_sincos(q.yaw, cy, sy);
    angle_sincos(q.roll, cr, sr);
    vx = longint'(signed'(q.vx));
    vy = longint'(signed'(q.vy));
    vz = longint'(signed'(q.vz));
    srsp = round_mul(sr, sp);
    crsp = round_mul(cr, sp);
    r.fwd = sat_dot(vx, vy, vz, round_mul(cp, cy), round_mul(cp, sy), -sp);
    r.side = sat_dot(vx, vy, vz,
                     round_mul(srsp, cy) - round_mul(cr, sy),
                     round_mul(srsp, sy) + round_mul(cr, cy),
                     round_mul(sr, cp));
    r.up = sat_dot(vx, vy, vz,
                   round_mul(crsp, cy) + round_mul(sr, sy),
                   round_mul(crsp, sy) - round_mul(sr, cy),
                   round_mul(cr, cp));
    return r;
  endfunction

  task automatic send_rotation(input rot_req_t q);
    while (($urandom_range(99, 0)) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.pitch <= q.pitch;
    in_ch.yaw   <= q.yaw;
    in_ch.roll  <= q.roll;
    in_ch.vec_x <= q.vx;
    in_ch.vec_y <= q.vy;
    in_ch.vec_z <= q.vz;
    do @(posedge clk); while (!in_ch.ready);
    rotated_q.push_back(rotate_vector(q));
    n_sent++;
    @(negedge clk);
  endtask

  function automatic rot_req_t random_rotation();
    rot_req_t q;
    q.pitch = 16'($urandom);
    q.yaw   = 16'($urandom);
    q.roll  = 16'($urandom);
    q.vx    = $urandom;
    q.vy    = $urandom;
    q.vz    = $urandom;
    case ($urandom_range(3, 0))
      0: begin
        q.vx = 32'(signed'(16'($urandom)));
        q.vy = 32'(signed'(16'($urandom)));
        q.vz = 32'(signed'(16'($urandom)));
      end
      1: begin
        q.vx = $urandom_range(1, 0) ? 32'h7fffffff : 32'h80000000;
        q.vy = $urandom_range(1, 0) ? 32'h7fffffff : 32'h80000000;
      end
      default: ;
    endcase
    return q;
  endfunction

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99, 0) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    rot_res_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (rotated_q.size() == 0) begin
        $error("result transaction with no expectation waiting");
        errors++;
      end else begin
        e = rotated_q.pop_front();
        n_checked++;
        if (out_ch.out_forward !== e.fwd) begin
          $error("out_forward expected %0d actual %0d", $signed(e.fwd),
                 $signed(out_ch.out_forward));
          errors++;
        end
        if (out_ch.out_side !== e.side) begin
          $error("out_side expected %0d actual %0d", $signed(e.side),
                 $signed(out_ch.out_side));
          errors++;
        end
        if (out_ch.out_up !== e.up) begin
          $error("out_up expected %0d actual %0d", $signed(e.up),
                 $signed(out_ch.out_up));
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    logic [15:0] angs[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hc000,
                             16'hffff, 16'h3fff, 16'h2000, 16'h0001};
    rot_req_t q;
    for (int i = 0; i < 8; i++) begin
      q = {angs[i], angs[(i + 3) % 8], angs[(i + 5) % 8],
           32'h0001_0000, 32'hffff_0000, 32'h0000_8000};
      send_rotation(q);
    end
    send_rotation({16'h0000, 16'h0000, 16'h0000, 32'h7fffffff, 32'h7fffffff,
                   32'h7fffffff});
    send_rotation({16'h2000, 16'h2000, 16'h2000, 32'h7fffffff, 32'h7fffffff,
                   32'h7fffffff});
    send_rotation({16'h2000, 16'he000, 16'h6000, 32'h80000000, 32'h80000000,
                   32'h80000000});
    send_rotation({16'hffff, 16'hffff, 16'hffff, 32'h0, 32'h0, 32'h0});
    send_rotation({16'h1234, 16'h5678, 16'h9abc, 32'h80000000, 32'h7fffffff,
                   32'hffffffff});
  endtask

  task automatic test_random(input int count, input int src_pct, input int dst_pct);
    in_idle_pct = src_pct;
    out_idle_pct = dst_pct;
    for (int i = 0; i < count; i++) send_rotation(random_rotation());
  endtask

  task automatic test_backpressure();
    in_idle_pct = 0;
    out_idle_pct = 0;
    hold_cycles = 200;
    for (int i = 0; i < 60; i++) send_rotation(random_rotation());
  endtask

  initial begin
    int wait_cycles;
    errors = 0; n_sent = 0; n_checked = 0; hold_cycles = 0;
    in_idle_pct = 0; out_idle_pct = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.pitch = '0; in_ch.yaw = '0; in_ch.roll = '0;
    in_ch.vec_x = '0; in_ch.vec_y = '0; in_ch.vec_z = '0;
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random(550, 10, 87);
    test_random(550, 87, 10);
    test_random(550, 0, 0);
    test_backpressure();
    test_random(40, 0, 0);
    in_ch.valid <= 1'b0;
    wait_cycles = 0;
    while (rotated_q.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (eavr_pkg::CORDIC_STEPS + 10) @(posedge clk);
    $display("Sent %0d rotation transactions, checked %0d results.", n_sent, n_checked);
    $display("Covered quadrant edges, saturation, random angles and output stalls.");
    if (errors == 0 && rotated_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
